// ===== design/lfcs_pkg.sv =====
// Shared types, constants and microcode word layout for the consensus step block.
package lfcs_pkg;

	// Defaults for the top-level parameters
	localparam int AGENT_COUNT_DEF = 8;
	localparam int STATE_WIDTH_DEF = 32;

	// Leader masks are always eight bits wide
	localparam int MASK_W = 8;
	localparam int GAIN_W = 16;
	localparam int DT_W   = 16;

	// Reset values: gains 1.0 and 1.5 in Q8.8, dt about 0.1 in Q0.16
	localparam logic [GAIN_W-1:0] POS_GAIN_RST = 16'd256;
	localparam logic [GAIN_W-1:0] VEL_GAIN_RST = 16'd384;
	localparam logic [DT_W-1:0]   STEP_RST     = 16'd6554;

	// Item function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// Register map
	localparam int ADDR_W = 3;
	typedef enum logic [0:0] {
		REG_STEP_SIZE = 1'b0
	} reg_idx_t;

	typedef struct packed {
		logic               func;
		logic [2:0]         agent_index;
		logic signed [31:0] init_position;
		logic signed [31:0] init_velocity;
		logic signed [31:0] init_drive;
		logic [15:0]        pos_gain;
		logic [15:0]        vel_gain;
		logic [7:0]         leader_mask;
	} in_word_t;

	typedef struct packed {
		logic [2:0]         out_agent;
		logic signed [31:0] out_position;
		logic signed [31:0] out_velocity;
		logic signed [31:0] out_drive;
		logic               last;
	} out_word_t;

	// Microprogram steps
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ_SELF,
		ST_LATCH,
		ST_PEER,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_MUL_V,
		ST_ADD_V,
		ST_MUL_X,
		ST_ADD_X,
		ST_EMIT,
		ST_NEXT,
		ST_FLIP
	} step_t;

	// Jump conditions
	typedef enum logic [2:0] {
		C_ALWAYS,
		C_START,
		C_PEER_LAST,
		C_OUT_FREE,
		C_AGENT_LAST
	} cond_t;

	// Operand select of the shared multiplier
	typedef enum logic [1:0] {
		MS_GAP,
		MS_DRIVE,
		MS_VEL
	} mul_src_t;

	// Datapath part of the control word
	typedef struct packed {
		logic     accept;
		logic     rd_peer;
		logic     latch_self;
		logic     issue;
		mul_src_t mul_src;
		logic     drive_load;
		logic     vnew_load;
		logic     commit;
		logic     emit;
		logic     flip;
	} ctrl_t;

	// Status fed back to the sequencer
	typedef struct packed {
		logic start;
		logic out_free;
	} stat_t;

	// Full control word
	typedef struct packed {
		ctrl_t dp;
		logic  i_inc;
		logic  i_clr;
		logic  j_inc;
		logic  j_clr;
		cond_t cond;
		step_t tgt;
		step_t alt;
	} seq_word_t;

endpackage

// ===== design/leader_follower_consensus_step.sv =====
// Top level: second-order leader/follower consensus engine with agent table.
//
// Usage
// - Item channel (item_valid/item_ready/item): a load word (func 0) writes one
//   agent's position, velocity, drive, gains and leader mask and produces
//   nothing. A tick word (func 1) advances every agent and produces one
//   result word per agent, agent 0 first, last=1 on the final one.
// - Result channel (result_valid/result_ready/result): one output register.
// - APB port: register 0 is step_size (dt, Q0.16), reset 6554. pready tied high.
// Sequencing
// - The peer loop of the microprogram visits min(AGENT_COUNT,8) peers, one
//   peer per cycle through two multipliers.
// - item_ready is high only while the sequencer idles; after the last result
//   enters the output register it rises once the next and flip steps are done.
// Stall: a full output register holds the sequencer at its emit step.
// Reset: state cleared to zero, gains 1.0/1.5, all agents leaders; no
// clearing pass is needed. Old state is double-banked so every agent of a
// tick sees the values from before the tick.
module leader_follower_consensus_step #(
	parameter int AGENT_COUNT = lfcs_pkg::AGENT_COUNT_DEF,
	parameter int STATE_WIDTH = lfcs_pkg::STATE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  lfcs_pkg::in_word_t            item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output lfcs_pkg::out_word_t           result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lfcs_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int IW   = $clog2(AGENT_COUNT);
	localparam int SW   = STATE_WIDTH;
	localparam int AW   = STATE_WIDTH + 1;           // gap / multiplier operand
	localparam int BW   = lfcs_pkg::GAIN_W + 1;      // gain or dt, zero-extended
	localparam int PW   = AW + BW;                   // product
	localparam int WIDE = (STATE_WIDTH + 14 > 33) ? STATE_WIDTH + 14 : 33;

	// ---------------------------------------------------------------- control
	lfcs_pkg::ctrl_t ctrl;
	lfcs_pkg::stat_t stat;
	logic [IW-1:0]   agent_idx, peer_idx;

	// ---------------------------------------------------------------- storage
	// position/velocity: two banks, read bank holds the pre-tick values
	logic signed [SW-1:0]         pos_q [2][AGENT_COUNT];
	logic signed [SW-1:0]         vel_q [2][AGENT_COUNT];
	logic signed [SW-1:0]         drv_q [AGENT_COUNT];
	logic [lfcs_pkg::GAIN_W-1:0]  pgain_q [AGENT_COUNT];
	logic [lfcs_pkg::GAIN_W-1:0]  vgain_q [AGENT_COUNT];
	logic [lfcs_pkg::MASK_W-1:0]  mask_q [AGENT_COUNT];
	logic                         bank_q;
	logic [lfcs_pkg::DT_W-1:0]    step_q;

	// ---------------------------------------------------------------- datapath regs
	logic signed [SW-1:0]         rd_x_s1, rd_v_s1;
	logic                         hit_s1, hit_s2;
	logic signed [PW-1:0]         prod_a_s2, prod_b_s2;
	logic signed [SW-1:0]         xi_q, vi_q, di_q;
	logic [lfcs_pkg::GAIN_W-1:0]  pg_self_q, vg_self_q;
	logic [lfcs_pkg::MASK_W-1:0]  mask_self_q;
	logic signed [WIDE-1:0]       acc_q;
	logic signed [SW-1:0]         drive_q, v_new_q;
	logic                         res_valid_q;
	lfcs_pkg::out_word_t          res_q;

	// ---------------------------------------------------------------- comb
	logic [IW-1:0]                rd_addr;
	logic signed [AW-1:0]         mul_a_op, gap_v;
	logic signed [BW-1:0]         mul_a_gain;
	logic signed [SW-1:0]         drive_sel, x_new;
	logic                         load_ok, out_free;
	logic [IW-1:0]                ld_idx;
	lfcs_pkg::reg_idx_t           reg_idx;

	// Clamp a wide signed value into the state width
	function automatic logic signed [SW-1:0] to_state(input logic signed [WIDE-1:0] v);
		logic fits;
		fits = (&v[WIDE-1:SW-1]) || !(|v[WIDE-1:SW-1]);
		if (fits) begin
			return v[SW-1:0];
		end else if (v[WIDE-1]) begin
			return {1'b1, {(SW-1){1'b0}}};
		end else begin
			return {1'b0, {(SW-1){1'b1}}};
		end
	endfunction

	// Clamp a state value to the 32-bit result fields
	function automatic logic signed [31:0] to_out(input logic signed [SW-1:0] s);
		logic signed [WIDE-1:0] v;
		logic fits;
		v = WIDE'(s);
		fits = (&v[WIDE-1:31]) || !(|v[WIDE-1:31]);
		if (fits) begin
			return v[31:0];
		end else if (v[WIDE-1]) begin
			return {1'b1, 31'd0};
		end else begin
			return {1'b0, {31{1'b1}}};
		end
	endfunction

	lfcs_seq #(
		.AGENT_COUNT(AGENT_COUNT)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.ctrl      (ctrl),
		.agent_idx (agent_idx),
		.peer_idx  (peer_idx)
	);

	assign item_ready   = ctrl.accept;
	assign out_free     = !res_valid_q || result_ready;
	assign stat.start   = item_valid && (item.func == lfcs_pkg::FUNC_TICK);
	assign stat.out_free = out_free;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// loads to agents beyond the table are dropped
	assign load_ok = item_valid && item_ready && (item.func == lfcs_pkg::FUNC_LOAD)
		&& ({29'd0, item.agent_index} < 32'(AGENT_COUNT));
	assign ld_idx  = IW'(item.agent_index);

	assign rd_addr = ctrl.rd_peer ? peer_idx : agent_idx;

	// leader keeps its stored drive; any nonzero mask makes a follower
	assign drive_sel = (mask_self_q != '0) ? to_state(acc_q) : di_q;

	// Shared multiplier operand select: gaps in the peer loop, dt products later
	always_comb begin
		gap_v = AW'(rd_v_s1) - AW'(vi_q);
		case (ctrl.mul_src)
			lfcs_pkg::MS_DRIVE: begin
				mul_a_op   = AW'(drive_sel);
				mul_a_gain = $signed({1'b0, step_q});
			end
			lfcs_pkg::MS_VEL: begin
				mul_a_op   = AW'(v_new_q);
				mul_a_gain = $signed({1'b0, step_q});
			end
			default: begin
				mul_a_op   = AW'(rd_x_s1) - AW'(xi_q);
				mul_a_gain = $signed({1'b0, pg_self_q});
			end
		endcase
	end

	assign x_new = to_state(WIDE'(xi_q) + WIDE'(prod_a_s2 >>> 16));

	// ---------------------------------------------------------------- agent table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < 2; b++) begin
				for (int a = 0; a < AGENT_COUNT; a++) begin
					pos_q[b][a] <= '0;
					vel_q[b][a] <= '0;
				end
			end
			for (int a = 0; a < AGENT_COUNT; a++) begin
				drv_q[a]   <= '0;
				pgain_q[a] <= lfcs_pkg::POS_GAIN_RST;
				vgain_q[a] <= lfcs_pkg::VEL_GAIN_RST;
				mask_q[a]  <= '0;
			end
			bank_q <= 1'b0;
		end else begin
			if (load_ok) begin
				pos_q[bank_q][ld_idx] <= to_state(WIDE'(item.init_position));
				vel_q[bank_q][ld_idx] <= to_state(WIDE'(item.init_velocity));
				drv_q[ld_idx]         <= to_state(WIDE'(item.init_drive));
				pgain_q[ld_idx]       <= item.pos_gain;
				vgain_q[ld_idx]       <= item.vel_gain;
				mask_q[ld_idx]        <= item.leader_mask;
			end
			// new state goes to the other bank; flipped once the tick is done
			if (ctrl.commit) begin
				pos_q[!bank_q][agent_idx] <= x_new;
				vel_q[!bank_q][agent_idx] <= v_new_q;
				drv_q[agent_idx]          <= drive_q;
			end
			if (ctrl.flip) begin
				bank_q <= !bank_q;
			end
		end
	end

	// ---------------------------------------------------------------- peer pipeline
	// s1: registered read of peer (or self) state, s2: products, then accumulate
	always_ff @(posedge clk) begin
		rd_x_s1   <= pos_q[bank_q][rd_addr];
		rd_v_s1   <= vel_q[bank_q][rd_addr];
		prod_a_s2 <= mul_a_op * mul_a_gain;
		prod_b_s2 <= gap_v * $signed({1'b0, vg_self_q});
		if (ctrl.latch_self) begin
			xi_q        <= rd_x_s1;
			vi_q        <= rd_v_s1;
			di_q        <= drv_q[agent_idx];
			pg_self_q   <= pgain_q[agent_idx];
			vg_self_q   <= vgain_q[agent_idx];
			mask_self_q <= mask_q[agent_idx];
		end
		if (ctrl.drive_load) begin
			drive_q <= drive_sel;
		end
		if (ctrl.vnew_load) begin
			v_new_q <= to_state(WIDE'(vi_q) + WIDE'(prod_a_s2 >>> 16));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
			hit_s2 <= 1'b0;
			acc_q  <= '0;
		end else begin
			hit_s1 <= ctrl.issue && mask_self_q[3'(peer_idx)];
			hit_s2 <= hit_s1;
			if (ctrl.latch_self) begin
				acc_q <= '0;
			end else if (hit_s2) begin
				// gain*gap is Q24.24; >>>8 floors back to Q16.16
				acc_q <= acc_q + WIDE'(prod_a_s2 >>> 8) + WIDE'(prod_b_s2 >>> 8);
			end
		end
	end

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctrl.emit && out_free) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// position written back at commit; the emit step reads it from the table
	always_ff @(posedge clk) begin
		if (ctrl.emit && out_free) begin
			res_q.out_agent    <= 3'(agent_idx);
			res_q.out_position <= to_out(pos_q[!bank_q][agent_idx]);
			res_q.out_velocity <= to_out(v_new_q);
			res_q.out_drive    <= to_out(drive_q);
			res_q.last         <= (agent_idx == IW'(AGENT_COUNT - 1));
		end
	end

	// ---------------------------------------------------------------- APB
	assign pready  = 1'b1;
	assign reg_idx = lfcs_pkg::reg_idx_t'(paddr[lfcs_pkg::ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= lfcs_pkg::STEP_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				lfcs_pkg::REG_STEP_SIZE: step_q <= pwdata[lfcs_pkg::DT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			lfcs_pkg::REG_STEP_SIZE: prdata = {{(32 - lfcs_pkg::DT_W){1'b0}}, step_q};
			default:                 prdata = '0;
		endcase
	end

endmodule

// ===== design/lfcs_seq.sv =====
// Microcode sequencer: step counter, control store and agent/peer counters.
module lfcs_seq #(
	parameter int AGENT_COUNT = lfcs_pkg::AGENT_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lfcs_pkg::stat_t                stat,
	output lfcs_pkg::ctrl_t                ctrl,
	output logic [$clog2(AGENT_COUNT)-1:0] agent_idx,
	output logic [$clog2(AGENT_COUNT)-1:0] peer_idx
);

	localparam int IW = $clog2(AGENT_COUNT);
	localparam int JN = (AGENT_COUNT < lfcs_pkg::MASK_W) ? AGENT_COUNT : lfcs_pkg::MASK_W;

	lfcs_pkg::step_t     pc_q, pc_d;
	lfcs_pkg::seq_word_t cw;
	logic [IW-1:0]       i_q, j_q;
	logic                cond_ok;

	// Control store
	function automatic lfcs_pkg::seq_word_t rom(input lfcs_pkg::step_t s);
		lfcs_pkg::seq_word_t w;
		w = '0;
		w.dp.mul_src = lfcs_pkg::MS_GAP;
		w.cond = lfcs_pkg::C_ALWAYS;
		w.tgt = lfcs_pkg::ST_IDLE;
		w.alt = lfcs_pkg::ST_IDLE;
		unique case (s)
			lfcs_pkg::ST_IDLE: begin
				w.dp.accept = 1'b1;
				w.cond = lfcs_pkg::C_START;
				w.tgt = lfcs_pkg::ST_READ_SELF;
				w.alt = lfcs_pkg::ST_IDLE;
			end
			lfcs_pkg::ST_READ_SELF: begin
				w.tgt = lfcs_pkg::ST_LATCH;
			end
			lfcs_pkg::ST_LATCH: begin
				w.dp.latch_self = 1'b1;
				w.j_clr = 1'b1;
				w.tgt = lfcs_pkg::ST_PEER;
			end
			lfcs_pkg::ST_PEER: begin
				w.dp.rd_peer = 1'b1;
				w.dp.issue = 1'b1;
				w.j_inc = 1'b1;
				w.cond = lfcs_pkg::C_PEER_LAST;
				w.tgt = lfcs_pkg::ST_DRAIN1;
				w.alt = lfcs_pkg::ST_PEER;
			end
			lfcs_pkg::ST_DRAIN1: begin
				w.tgt = lfcs_pkg::ST_DRAIN2;
			end
			lfcs_pkg::ST_DRAIN2: begin
				w.tgt = lfcs_pkg::ST_MUL_V;
			end
			lfcs_pkg::ST_MUL_V: begin
				w.dp.mul_src = lfcs_pkg::MS_DRIVE;
				w.dp.drive_load = 1'b1;
				w.tgt = lfcs_pkg::ST_ADD_V;
			end
			lfcs_pkg::ST_ADD_V: begin
				w.dp.vnew_load = 1'b1;
				w.tgt = lfcs_pkg::ST_MUL_X;
			end
			lfcs_pkg::ST_MUL_X: begin
				w.dp.mul_src = lfcs_pkg::MS_VEL;
				w.tgt = lfcs_pkg::ST_ADD_X;
			end
			lfcs_pkg::ST_ADD_X: begin
				w.dp.commit = 1'b1;
				w.tgt = lfcs_pkg::ST_EMIT;
			end
			lfcs_pkg::ST_EMIT: begin
				w.dp.emit = 1'b1;
				w.cond = lfcs_pkg::C_OUT_FREE;
				w.tgt = lfcs_pkg::ST_NEXT;
				w.alt = lfcs_pkg::ST_EMIT;
			end
			lfcs_pkg::ST_NEXT: begin
				w.i_inc = 1'b1;
				w.cond = lfcs_pkg::C_AGENT_LAST;
				w.tgt = lfcs_pkg::ST_FLIP;
				w.alt = lfcs_pkg::ST_READ_SELF;
			end
			lfcs_pkg::ST_FLIP: begin
				w.dp.flip = 1'b1;
				w.i_clr = 1'b1;
				w.tgt = lfcs_pkg::ST_IDLE;
			end
			default: begin
				w.tgt = lfcs_pkg::ST_IDLE;
			end
		endcase
		return w;
	endfunction

	assign cw        = rom(pc_q);
	assign ctrl      = cw.dp;
	assign agent_idx = i_q;
	assign peer_idx  = j_q;

	always_comb begin
		unique case (cw.cond)
			lfcs_pkg::C_ALWAYS:     cond_ok = 1'b1;
			lfcs_pkg::C_START:      cond_ok = stat.start;
			lfcs_pkg::C_PEER_LAST:  cond_ok = (j_q == IW'(JN - 1));
			lfcs_pkg::C_OUT_FREE:   cond_ok = stat.out_free;
			lfcs_pkg::C_AGENT_LAST: cond_ok = (i_q == IW'(AGENT_COUNT - 1));
			default:                cond_ok = 1'b1;
		endcase
		pc_d = cond_ok ? cw.tgt : cw.alt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= lfcs_pkg::ST_IDLE;
			i_q  <= '0;
			j_q  <= '0;
		end else begin
			pc_q <= pc_d;
			if (cw.i_clr) begin
				i_q <= '0;
			end else if (cw.i_inc) begin
				i_q <= i_q + 1'b1;
			end
			if (cw.j_clr) begin
				j_q <= '0;
			end else if (cw.j_inc) begin
				j_q <= j_q + 1'b1;
			end
		end
	end

endmodule

// ===== design/lfcs_checker.sv =====
// Port-level checker for the consensus step block, bound to the top level.
module lfcs_checker #(
	parameter int AGENT_COUNT = lfcs_pkg::AGENT_COUNT_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input lfcs_pkg::in_word_t  item,
	input logic                result_valid,
	input logic                result_ready,
	input lfcs_pkg::out_word_t result
);

	// stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// a tick keeps the block busy
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item.func == lfcs_pkg::FUNC_TICK) |=> !item_ready)
		else $error("block idle right after a tick");

	// the last flag marks the final agent
	a_last_agent: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> result.out_agent == 3'(AGENT_COUNT - 1))
		else $error("last flag on wrong agent");

	// no new item while a tick is still emitting
	a_mid_tick: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> !item_ready)
		else $error("item accepted in the middle of a tick");

endmodule

bind leader_follower_consensus_step lfcs_checker #(
	.AGENT_COUNT(AGENT_COUNT)
) u_lfcs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
